// ===== hdl/spcm_pkg.sv =====
`default_nettype none
package spcm_pkg;

  localparam int MAX_WINDOW_DEF  = 4096;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int CFG_BITS        = 13;
  localparam int WINDOW_RESET    = 1024;
  localparam int OUT_BITS        = 16;
  localparam int NORM_BITS       = 48;
  localparam int QUO_BITS        = 16;
  localparam int MAC_STEPS       = 6;
  localparam logic [OUT_BITS-1:0] Q_FULL = 16'h8000;
  localparam logic [OUT_BITS-1:0] Q_MAX  = 16'h7FFF;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_FETCH, OP_MUL, OP_ZERO, OP_PINIT, OP_PSTEP,
    OP_SINIT, OP_SSTEP, OP_NORM, OP_DINIT, OP_DSTEP, OP_FINISH
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] step;
  } dp_cmd_t;

  typedef struct packed {
    logic zero_energy;
    logic need_norm;
    logic root_zero;
    logic out_busy;
  } dp_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FETCH, ST_MAC, ST_CHK, ST_PMUL, ST_SINIT, ST_SQRT,
    ST_NORM, ST_DINIT, ST_DIV, ST_DONE
  } state_t;

  // width of one energy sum: square of a sample times the window depth
  function automatic int energy_bits(input int sb, input int mw);
    return 2 * sb - 1 + $clog2(mw);
  endfunction

endpackage
`default_nettype wire

// ===== hdl/spcm_datapath.sv =====
`default_nettype none
module spcm_datapath #(
  parameter int MAX_WINDOW  = spcm_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = spcm_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [spcm_pkg::CFG_BITS-1:0]       cfg_window_length,
  input  wire logic signed [SAMPLE_BITS-1:0]       in_left_sample,
  input  wire logic signed [SAMPLE_BITS-1:0]       in_right_sample,
  input  wire logic                                out_stall,
  input  spcm_pkg::dp_cmd_t                        cmd,
  output spcm_pkg::dp_stat_t                       stat,
  output logic                                     out_valid,
  output logic signed [spcm_pkg::OUT_BITS-1:0]     out_correlation
);

  localparam int SB   = SAMPLE_BITS;
  localparam int AW   = $clog2(MAX_WINDOW);
  localparam int WLW  = $clog2(MAX_WINDOW + 1);
  localparam int PRW  = 2 * SB;
  localparam int CW   = 2 * SB + AW;
  localparam int EW   = spcm_pkg::energy_bits(SB, MAX_WINDOW);
  localparam int PW   = 2 * EW;
  localparam int RW   = EW;
  localparam int WRST = (spcm_pkg::WINDOW_RESET < MAX_WINDOW) ?
                        spcm_pkg::WINDOW_RESET : MAX_WINDOW;

  logic [PRW-1:0]          mem [MAX_WINDOW];
  logic [PRW-1:0]          mem_q_r;
  logic [WLW-1:0]          wl_r;
  logic [AW-1:0]           pos_r;
  logic                    wrapped_r;
  logic signed [SB-1:0]    l_r, r_r, ol_r, or_r;
  logic signed [PRW-1:0]   prod_r;
  logic signed [CW-1:0]    cross_r;
  logic [EW-1:0]           le_r, re_r;
  logic [PW-1:0]           p_r, pa_r;
  logic [EW-1:0]           pb_r;
  logic [CW-1:0]           mag_r;
  logic                    neg_r;
  logic [RW+1:0]           rem_r;
  logic [RW-1:0]           root_r;
  logic [RW:0]             drem_r;
  logic [spcm_pkg::OUT_BITS-1:0] q_r;
  logic                    out_valid_r;
  logic signed [spcm_pkg::OUT_BITS-1:0] out_corr_r;

  logic signed [SB-1:0]    ma, mb;
  logic signed [CW-1:0]    prod_x;
  logic [AW:0]             pos_inc;
  logic [31:0]             wl_c;
  logic [RW+3:0]           rem_t, trial;
  logic                    sge, dge;
  logic [RW:0]             dsub;

  always_comb begin
    unique case (cmd.step)
      3'd0:    begin ma = l_r;  mb = r_r;  end
      3'd1:    begin ma = ol_r; mb = or_r; end
      3'd2:    begin ma = l_r;  mb = l_r;  end
      3'd3:    begin ma = ol_r; mb = ol_r; end
      3'd4:    begin ma = r_r;  mb = r_r;  end
      3'd5:    begin ma = or_r; mb = or_r; end
      default: begin ma = l_r;  mb = r_r;  end
    endcase
  end

  assign prod_x  = {{(CW-PRW){prod_r[PRW-1]}}, prod_r};
  assign pos_inc = {1'b0, pos_r} + 1'b1;

  always_comb begin
    wl_c = 32'(cfg_window_length);
    if (wl_c == 32'd0) wl_c = 32'd1;
    else if (wl_c > 32'(MAX_WINDOW)) wl_c = 32'(MAX_WINDOW);
  end

  assign rem_t = {rem_r, p_r[PW-1:PW-2]};
  assign trial = {2'b00, root_r, 2'b01};
  assign sge   = rem_t >= trial;
  assign dge   = drem_r >= {1'b0, root_r};
  assign dsub  = dge ? drem_r - {1'b0, root_r} : drem_r;

  always_ff @(posedge clk) begin
    if (cmd.op == spcm_pkg::OP_FETCH) mem[pos_r] <= {l_r, r_r};
    mem_q_r <= mem[pos_r];
  end

  // window register, write pointer and running sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r      <= WLW'(WRST);
      pos_r     <= '0;
      wrapped_r <= 1'b0;
      cross_r   <= '0;
      le_r      <= '0;
      re_r      <= '0;
    end else if (cfg_we) begin
      wl_r      <= WLW'(wl_c);
      pos_r     <= '0;
      wrapped_r <= 1'b0;
      cross_r   <= '0;
      le_r      <= '0;
      re_r      <= '0;
    end else begin
      if (cmd.op == spcm_pkg::OP_FETCH) begin
        if (32'(pos_inc) >= 32'(wl_r)) begin
          pos_r     <= '0;
          wrapped_r <= 1'b1;
        end else begin
          pos_r <= pos_inc[AW-1:0];
        end
      end
      if (cmd.op == spcm_pkg::OP_MUL) begin
        case (cmd.step)
          3'd1:    cross_r <= cross_r + prod_x;
          3'd2:    cross_r <= cross_r - prod_x;
          3'd3:    le_r    <= le_r + EW'(prod_x);
          3'd4:    le_r    <= le_r - EW'(prod_x);
          3'd5:    re_r    <= re_r + EW'(prod_x);
          3'd6:    re_r    <= re_r - EW'(prod_x);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      spcm_pkg::OP_LOAD: begin
        l_r <= in_left_sample;
        r_r <= in_right_sample;
      end
      spcm_pkg::OP_FETCH: begin
        // unwritten entries since the last clear count as zero pairs
        ol_r <= wrapped_r ? $signed(mem_q_r[PRW-1:SB]) : '0;
        or_r <= wrapped_r ? $signed(mem_q_r[SB-1:0]) : '0;
      end
      spcm_pkg::OP_MUL: prod_r <= ma * mb;
      spcm_pkg::OP_ZERO: begin
        q_r   <= '0;
        neg_r <= 1'b0;
      end
      spcm_pkg::OP_PINIT: begin
        p_r   <= '0;
        pa_r  <= PW'(le_r);
        pb_r  <= re_r;
        neg_r <= cross_r[CW-1];
        mag_r <= cross_r[CW-1] ? CW'(-cross_r) : CW'(cross_r);
      end
      spcm_pkg::OP_PSTEP: begin
        if (pb_r[0]) p_r <= p_r + pa_r;
        pa_r <= pa_r << 1;
        pb_r <= pb_r >> 1;
      end
      spcm_pkg::OP_SINIT: begin
        rem_r  <= '0;
        root_r <= '0;
      end
      spcm_pkg::OP_SSTEP: begin
        rem_r  <= (RW+2)'(sge ? rem_t - trial : rem_t);
        root_r <= {root_r[RW-2:0], sge};
        p_r    <= p_r << 2;
      end
      spcm_pkg::OP_NORM: begin
        mag_r  <= mag_r >> 1;
        root_r <= root_r >> 1;
      end
      spcm_pkg::OP_DINIT: begin
        drem_r <= (RW+1)'(mag_r);
        q_r    <= (root_r == '0) ? spcm_pkg::Q_FULL : '0;
      end
      spcm_pkg::OP_DSTEP: begin
        drem_r <= {dsub[RW-1:0], 1'b0};
        q_r    <= {q_r[spcm_pkg::OUT_BITS-2:0], dge};
      end
      spcm_pkg::OP_FINISH: begin
        if (neg_r) out_corr_r <= $signed(-q_r);
        else if (q_r > spcm_pkg::Q_MAX) out_corr_r <= $signed(spcm_pkg::Q_MAX);
        else out_corr_r <= $signed(q_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.op == spcm_pkg::OP_FINISH) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  assign stat.zero_energy = (le_r == '0) || (re_r == '0);
  assign stat.need_norm   = (mag_r >> spcm_pkg::NORM_BITS) != '0;
  assign stat.root_zero   = root_r == '0;
  assign stat.out_busy    = out_valid_r && out_stall;

  assign out_valid       = out_valid_r;
  assign out_correlation = out_corr_r;

`ifndef SYNTH
  a_pos_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    32'(pos_r) < 32'(wl_r)) else $error("write pointer outside window");
  a_window_range: assert property (@(posedge clk) disable iff (!rst_n)
    (wl_r != '0) && (32'(wl_r) <= 32'(MAX_WINDOW))) else $error("window out of range");
  a_quotient_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == spcm_pkg::OP_FINISH) |-> (q_r <= spcm_pkg::Q_FULL))
    else $error("ratio above full scale");
`endif

endmodule
`default_nettype wire

// ===== hdl/spcm_controller.sv =====
`default_nettype none
module spcm_controller #(
  parameter int MAX_WINDOW  = spcm_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = spcm_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  spcm_pkg::dp_stat_t stat,
  output spcm_pkg::dp_cmd_t  cmd
);

  localparam int EW   = spcm_pkg::energy_bits(SAMPLE_BITS, MAX_WINDOW);
  localparam int CNTW = $clog2(EW + 1);

  spcm_pkg::state_t state_r, state_nxt;
  logic [CNTW-1:0]  cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spcm_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd.op    = spcm_pkg::OP_NONE;
    cmd.step  = cnt_r[2:0];
    in_stall  = 1'b1;
    unique case (state_r)
      spcm_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op    = spcm_pkg::OP_LOAD;
          state_nxt = spcm_pkg::ST_FETCH;
        end
      end
      spcm_pkg::ST_FETCH: begin
        cmd.op    = spcm_pkg::OP_FETCH;
        cnt_nxt   = '0;
        state_nxt = spcm_pkg::ST_MAC;
      end
      spcm_pkg::ST_MAC: begin
        cmd.op  = spcm_pkg::OP_MUL;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNTW'(spcm_pkg::MAC_STEPS)) state_nxt = spcm_pkg::ST_CHK;
      end
      spcm_pkg::ST_CHK: begin
        cnt_nxt = '0;
        if (stat.zero_energy) begin
          cmd.op    = spcm_pkg::OP_ZERO;
          state_nxt = spcm_pkg::ST_DONE;
        end else begin
          cmd.op    = spcm_pkg::OP_PINIT;
          state_nxt = spcm_pkg::ST_PMUL;
        end
      end
      spcm_pkg::ST_PMUL: begin
        cmd.op  = spcm_pkg::OP_PSTEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNTW'(EW - 1)) state_nxt = spcm_pkg::ST_SINIT;
      end
      spcm_pkg::ST_SINIT: begin
        cmd.op    = spcm_pkg::OP_SINIT;
        cnt_nxt   = '0;
        state_nxt = spcm_pkg::ST_SQRT;
      end
      spcm_pkg::ST_SQRT: begin
        cmd.op  = spcm_pkg::OP_SSTEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNTW'(EW - 1)) state_nxt = spcm_pkg::ST_NORM;
      end
      spcm_pkg::ST_NORM: begin
        if (stat.need_norm) cmd.op = spcm_pkg::OP_NORM;
        else state_nxt = spcm_pkg::ST_DINIT;
      end
      spcm_pkg::ST_DINIT: begin
        cmd.op    = spcm_pkg::OP_DINIT;
        cnt_nxt   = '0;
        state_nxt = stat.root_zero ? spcm_pkg::ST_DONE : spcm_pkg::ST_DIV;
      end
      spcm_pkg::ST_DIV: begin
        cmd.op  = spcm_pkg::OP_DSTEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNTW'(spcm_pkg::QUO_BITS - 1)) state_nxt = spcm_pkg::ST_DONE;
      end
      spcm_pkg::ST_DONE: begin
        // hold until the previous beat has left the output register
        if (!stat.out_busy) begin
          cmd.op    = spcm_pkg::OP_FINISH;
          state_nxt = spcm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = spcm_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/stereo_phase_correlation_meter.sv =====
`default_nettype none
// Stereo phase correlation over a sliding window of window_length pairs.
// One pair is taken at a time. The energy sum width is 2*SAMPLE_BITS-1 +
// log2 MAX_WINDOW, 43 by default. An item with signal on both channels runs
// the bit-serial multiply of the two energy sums, the two-bit-per-cycle
// square root, the extra scaling steps needed only by wide sums and the
// 16-step divide; an item whose window has no energy in a channel skips them.
// A finished result waits for the previous beat to leave the output
// register. A finished result may wait in the output register while the
// next pair is taken in. A reset or a window_length write empties the
// history at once.
module stereo_phase_correlation_meter #(
  parameter int MAX_WINDOW  = spcm_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = spcm_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [spcm_pkg::CFG_BITS-1:0]   cfg_window_length,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0]   in_left_sample,
  input  wire logic signed [SAMPLE_BITS-1:0]   in_right_sample,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic signed [spcm_pkg::OUT_BITS-1:0] out_correlation
);

  spcm_pkg::dp_cmd_t  cmd;
  spcm_pkg::dp_stat_t stat;

  spcm_controller #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  spcm_datapath #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_window_length (cfg_window_length),
    .in_left_sample    (in_left_sample),
    .in_right_sample   (in_right_sample),
    .out_stall         (out_stall),
    .cmd               (cmd),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_correlation   (out_correlation)
  );

endmodule
`default_nettype wire

// ===== verif/stereo_phase_correlation_meter_test.sv =====
`timescale 1ns / 100ps
`default_nettype none
module stereo_phase_correlation_meter_test;

  localparam int DEPTH = spcm_pkg::MAX_WINDOW_DEF;
  localparam int CFG_W = spcm_pkg::CFG_BITS;
  localparam int CYCLE_LIMIT = 2_000_000;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
  } pair_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_window_length = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_left_sample = '0;
  logic signed [15:0] in_right_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [spcm_pkg::OUT_BITS-1:0] out_correlation;

  stereo_phase_correlation_meter DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_window_length(cfg_window_length),
    .in_valid(in_valid), .in_stall(in_stall), .in_left_sample(in_left_sample),
    .in_right_sample(in_right_sample), .out_valid(out_valid), .out_stall(out_stall),
    .out_correlation(out_correlation)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state
  logic signed [15:0] hist_l [DEPTH];
  logic signed [15:0] hist_r [DEPTH];
  int unsigned wr_pos;
  int unsigned win_len;
  longint cross_acc, left_acc, right_acc;

  pair_t pending_pairs[$];
  logic signed [15:0] expected_corr[$];
  int errors = 0;
  int unsigned cycles = 0;

  function automatic void clear_window();
    for (int i = 0; i < DEPTH; i++) begin
      hist_l[i] = '0;
      hist_r[i] = '0;
    end
    wr_pos = 0;
    cross_acc = 0;
    left_acc = 0;
    right_acc = 0;
  endfunction

  function automatic logic signed [15:0] correlate(logic signed [15:0] l,
                                                   logic signed [15:0] r);
    longint ll, rr, ol, orr;
    logic [127:0] prod, sq;
    logic [63:0] root, cand, mag, quo;
    logic neg;
    int unsigned pos;
    ll = l;
    rr = r;
    pos = wr_pos;
    if (pos >= win_len) pos = 0;
    ol = hist_l[pos];
    orr = hist_r[pos];
    cross_acc += ll * rr - ol * orr;
    left_acc += ll * ll - ol * ol;
    right_acc += rr * rr - orr * orr;
    hist_l[pos] = l;
    hist_r[pos] = r;
    pos++;
    if (pos >= win_len) pos = 0;
    wr_pos = pos;
    if (left_acc <= 0 || right_acc <= 0) return '0;
    prod = {64'd0, left_acc} * {64'd0, right_acc};
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      sq = {64'd0, cand} * {64'd0, cand};
      if (sq <= prod) root = cand;
    end
    neg = cross_acc < 0;
    mag = neg ? -cross_acc : cross_acc;
    while (mag >> 48 != 0) begin
      mag = mag >> 1;
      root = root >> 1;
    end
    quo = (root == 0) ? 64'd32768 : (mag << 15) / root;
    if (neg) begin
      if (quo > 64'd32768) quo = 64'd32768;
      return -quo[15:0];
    end
    if (quo > 64'd32767) quo = 64'd32767;
    return quo[15:0];
  endfunction

  // sender
  int send_gap = 0;
  logic sent_last = 1'b0;
  logic send_burst = 1'b0;
  always @(negedge clk) begin
    if (in_valid && !sent_last) begin
      // hold stalled beat
    end else if (send_gap > 0) begin
      in_valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending_pairs.size() != 0) begin
      pair_t p;
      p = pending_pairs[0];
      pending_pairs.delete(0);
      in_valid <= 1'b1;
      in_left_sample <= p.left;
      in_right_sample <= p.right;
      if ($urandom_range(0, 63) == 0) send_burst <= ~send_burst;
      send_gap <= send_burst ? 0 : $urandom_range(0, 11);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver
  int recv_gap = 0;
  logic recv_burst = 1'b0;
  logic got_last = 1'b0;
  always @(negedge clk) begin
    if (got_last || (!out_valid && !out_stall)) begin
      if ($urandom_range(0, 63) == 0) recv_burst <= ~recv_burst;
      recv_gap <= recv_burst ? 0 : $urandom_range(0, 11);
      out_stall <= !recv_burst && recv_gap != 0;
    end else if (recv_gap > 0) begin
      out_stall <= 1'b1;
      recv_gap <= recv_gap - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // accept inputs, predict, check results
  always @(posedge clk) begin
    sent_last <= in_valid && !in_stall && rst_n;
    got_last <= out_valid && !out_stall && rst_n;
    if (rst_n && in_valid && !in_stall)
      expected_corr.insert(expected_corr.size(), correlate(in_left_sample, in_right_sample));
    if (rst_n && out_valid && !out_stall) begin
      if (expected_corr.size() == 0) begin
        $error("unexpected beat: correlation %0d", out_correlation);
        errors++;
      end else begin
        logic signed [15:0] want;
        want = expected_corr[0];
        expected_corr.delete(0);
        if (want !== out_correlation) begin
          $error("correlation: expected %0d, got %0d", want, out_correlation);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic drain();
    while (pending_pairs.size() != 0 || in_valid || expected_corr.size() != 0)
      @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic set_window(logic [CFG_W-1:0] value);
    int unsigned v;
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_window_length <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    v = value;
    if (v < 1) v = 1;
    if (v > DEPTH) v = DEPTH;
    win_len = v;
    clear_window();
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 15) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    p.left = rand_sample();
    case ($urandom_range(0, 7))
      0: p.right = p.left;
      1: p.right = -p.left;
      2: p.right = p.left >>> $urandom_range(1, 8);
      3: p.right = '0;
      4: p.right = p.left + 16'($urandom_range(0, 255) - 128);
      default: p.right = rand_sample();
    endcase
    if ($urandom_range(0, 15) == 0) p.left = '0;
    return p;
  endfunction

  task automatic push(logic signed [15:0] l, logic signed [15:0] r);
    pair_t p;
    p.left = l;
    p.right = r;
    pending_pairs.insert(pending_pairs.size(), p);
  endtask

  initial begin
    logic [CFG_W-1:0] windows [8];
    win_len = spcm_pkg::WINDOW_RESET;
    clear_window();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // no energy, full scale both ways, extremes, reset window length
    push(0, 0);
    push(16'sh7FFF, 0);
    push(0, 16'sh7FFF);
    push(16'sh7FFF, 16'sh7FFF);
    push(16'sh8000, 16'sh8000);
    push(16'sh8000, 16'sh7FFF);
    push(16'sh7FFF, 16'sh8000);
    push(1, -1);
    push(-1, -1);
    push(100, 50);
    push(16'sh5555, 16'shAAAA);
    push(16'shAAAA, 16'sh5555);
    drain();
    // window of one: each result comes from a single pair
    set_window(1);
    push(16'sh8000, 16'sh8000);
    push(16'sh8000, 16'sh7FFF);
    push(0, 5);
    push(3, -7);
    // window length zero is taken as one, above the maximum saturates
    set_window(0);
    push(7, -7);
    push(0, 0);
    set_window(13'h1FFF);
    push(16'sh7FFF, 16'sh7FFF);
    push(-5, 9);

    windows[0] = 1;
    windows[1] = 2;
    windows[2] = CFG_W'($urandom_range(3, 16));
    windows[3] = CFG_W'($urandom_range(17, 200));
    windows[4] = CFG_W'(DEPTH);
    windows[5] = 0;
    windows[6] = 13'h1FFF;
    windows[7] = CFG_W'($urandom_range(201, 4095));
    for (int ph = 0; ph < 8; ph++) begin
      set_window(windows[ph]);
      for (int i = 0; i < 155; i++) begin
        pending_pairs.insert(pending_pairs.size(), rand_pair());
        // pause the sender until all results are back
        if (i == 77 && ph == 3) drain();
      end
    end

    drain();
    if (expected_corr.size() != 0) begin
      $error("%0d results never arrived", expected_corr.size());
      errors++;
    end
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire
